### rtl/barometric_pressure_compensation_unit_defines.svh
// assertion macros for the pressure compensation unit
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH

// checked property with reset masking, sampled on clk
`define BPCU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked property that also holds while in reset
`define BPCU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bpcu_pkg.sv
// shared types, constants and helpers of the pressure compensation unit
package bpcu_pkg;

	localparam int unsigned DIV_W = 32;
	// cycles from the accepting edge to the edge that takes the result
	localparam int unsigned LATENCY = 2 + DIV_W + 6 + DIV_W + 4;

	localparam logic [31:0] TEMP_OFS = 32'd4000;
	localparam logic [31:0] P_SCALE = 32'd50000;
	localparam logic [31:0] B4_OFS = 32'd32768;
	localparam logic [31:0] K_SQ = 32'd3038;
	localparam logic [31:0] K_LIN = 32'hFFFF_E343;
	localparam logic [31:0] K_OFS = 32'd3791;

	typedef enum logic [1:0] {
		REG_CALIB_A = 2'd0,
		REG_CALIB_B = 2'd1,
		REG_CALIB_C = 2'd2,
		REG_OSS = 2'd3
	} reg_idx_t;

	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
		return $unsigned($signed(v) >>> s);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

### rtl/bpcu_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
module bpcu_div
	import bpcu_pkg::*;
#(
	parameter int unsigned SW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [DIV_W-1:0]  in_num,
	input  logic [DIV_W-1:0]  in_den,
	input  logic [SW-1:0]     in_side,
	output logic              out_valid,
	output logic [DIV_W-1:0]  out_quot,
	output logic [SW-1:0]     out_side
);

	logic [DIV_W:0]    vld_s;
	logic [DIV_W-1:0]  rem_s [DIV_W+1];
	logic [DIV_W-1:0]  num_s [DIV_W+1];
	logic [DIV_W-1:0]  den_s [DIV_W+1];
	logic [DIV_W-1:0]  quo_s [DIV_W+1];
	logic [SW-1:0]     side_s [DIV_W+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign num_s[0]  = in_num;
	assign den_s[0]  = in_den;
	assign quo_s[0]  = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < DIV_W; k++) begin : g_stage
		logic [DIV_W:0]   trial;
		logic [DIV_W:0]   diff;
		logic             qbit;

		always_comb begin
			trial = {rem_s[k], num_s[k][DIV_W-1]};
			diff  = trial - {1'b0, den_s[k]};
			qbit  = (trial >= {1'b0, den_s[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			num_s[k+1]  <= {num_s[k][DIV_W-2:0], 1'b0};
			den_s[k+1]  <= den_s[k];
			quo_s[k+1]  <= {quo_s[k][DIV_W-2:0], qbit};
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = vld_s[DIV_W];
	assign out_quot  = quo_s[DIV_W];
	assign out_side  = side_s[DIV_W];

endmodule

### rtl/barometric_pressure_compensation_unit.sv
// top level of the barometric pressure compensation unit
//  channel   | signals                                   | transfer
//  input     | start, busy, raw_temp, raw_press          | start && !busy at a rising edge
//  result    | done, temp_tenths, pressure_pa, div_error | done high for one cycle
//  config    | psel, penable, pwrite, paddr, pwdata, ... | psel && penable && pwrite
// one item enters every cycle; busy is always low
// a result passes through the two 32-stage dividers and the registered stages around them
// reset clears valid bits and the config registers (oversampling to 1)
// results are never held back: no stall path exists
module barometric_pressure_compensation_unit
	import bpcu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] raw_temp,
	input  logic [18:0] raw_press,
	output logic        done,
	output logic [31:0] temp_tenths,
	output logic [31:0] pressure_pa,
	output logic        div_error,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int unsigned SW1 = 19 + 32 + 2;
	localparam int unsigned SW2 = 32 + 2;

	logic [47:0] calib_a_q;
	logic [47:0] calib_b_q;
	logic [63:0] calib_c_q;
	logic [1:0]  oss_q;
	reg_idx_t    widx;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign widx   = reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_a_q <= '0;
			calib_b_q <= '0;
			calib_c_q <= '0;
			oss_q     <= 2'd1;
		end else if (psel && penable && pwrite && pready) begin
			unique case (widx)
				REG_CALIB_A: calib_a_q <= pwdata[47:0];
				REG_CALIB_B: calib_b_q <= pwdata[47:0];
				REG_CALIB_C: calib_c_q <= pwdata;
				REG_OSS:     oss_q <= pwdata[1:0];
				default:     calib_a_q <= calib_a_q;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_CALIB_A: prdata = {16'd0, calib_a_q};
			REG_CALIB_B: prdata = {16'd0, calib_b_q};
			REG_CALIB_C: prdata = calib_c_q;
			REG_OSS:     prdata = {62'd0, oss_q};
			default:     prdata = '0;
		endcase
	end

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = sx16(calib_a_q[47:32]);
	assign ac2 = sx16(calib_a_q[31:16]);
	assign ac3 = sx16(calib_a_q[15:0]);
	assign ac4 = {16'd0, calib_b_q[47:32]};
	assign ac5 = {16'd0, calib_b_q[31:16]};
	assign ac6 = {16'd0, calib_b_q[15:0]};
	assign b1  = sx16(calib_c_q[63:48]);
	assign b2  = sx16(calib_c_q[47:32]);
	assign mc  = sx16(calib_c_q[31:16]);
	assign md  = sx16(calib_c_q[15:0]);

	// stage 1: (ut - ac6) * ac5
	logic        v_s1;
	logic [31:0] p_s1;
	logic [18:0] up_s1;

	// stage 2: temperature divider setup
	logic           v_s2;
	logic [31:0]    num_s2, den_s2;
	logic [SW1-1:0] side_s2;
	logic [31:0]    x1a, dsum, tnum;

	always_comb begin
		x1a  = asr(p_s1, 5'd15);
		dsum = x1a + md;
		tnum = mc << 11;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1    <= ({16'd0, raw_temp} - ac6) * ac5;
		up_s1   <= raw_press;
		num_s2  <= tnum[31] ? (32'd0 - tnum) : tnum;
		den_s2  <= (dsum == 32'd0) ? 32'd1 : (dsum[31] ? (32'd0 - dsum) : dsum);
		side_s2 <= {up_s1, x1a, tnum[31] ^ dsum[31], dsum == 32'd0};
	end

	logic           v_d1;
	logic [31:0]    q_d1;
	logic [SW1-1:0] side_d1;

	bpcu_div #(.SW(SW1)) u_div_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_num    (num_s2),
		.in_den    (den_s2),
		.in_side   (side_s2),
		.out_valid (v_d1),
		.out_quot  (q_d1),
		.out_side  (side_d1)
	);

	// stage 3: b5, temperature, b6
	logic        v_s3, dz_s3;
	logic [31:0] temp_s3, b6_s3;
	logic [18:0] up_s3;
	logic [31:0] x2t, b5;

	always_comb begin
		x2t = side_d1[1] ? (32'd0 - q_d1) : q_d1;
		b5  = side_d1[33:2] + x2t;
	end

	// stage 4: products of b6
	logic        v_s4, dz_s4;
	logic [31:0] temp_s4, sq_s4, t2_s4, t3_s4;
	logic [18:0] up_s4;

	// stage 5: products of b6 squared
	logic        v_s5, dz_s5;
	logic [31:0] temp_s5, u1_s5, u4_s5, t2_s5, t3_s5;
	logic [18:0] up_s5;

	// stage 6: b3 and the b4 term
	logic        v_s6, dz_s6;
	logic [31:0] temp_s6, b3_s6, y3_s6;
	logic [18:0] up_s6;
	logic [31:0] x3c, b3v, y3c;

	always_comb begin
		x3c = asr(asr(u1_s5, 5'd12), 5'd11) + asr(t2_s5, 5'd11);
		b3v = (((ac1 << 2) + x3c) << oss_q) + 32'd2;
		y3c = asr(asr(t3_s5, 5'd13) + asr(asr(u4_s5, 5'd12), 5'd16) + 32'd2, 5'd2);
	end

	// stage 7: b4 product and b7
	logic        v_s7, dz_s7;
	logic [31:0] temp_s7, b4p_s7, b7_s7;

	// stage 8: pressure divider setup
	logic           v_s8;
	logic [31:0]    num_s8, den_s8;
	logic [SW2-1:0] side_s8;
	logic [31:0]    b4;

	assign b4 = b4p_s7 >> 15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s3 <= v_d1;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		dz_s3   <= side_d1[0];
		up_s3   <= side_d1[52:34];
		temp_s3 <= side_d1[0] ? 32'd0 : asr(b5 + 32'd8, 5'd4);
		b6_s3   <= b5 - TEMP_OFS;

		dz_s4   <= dz_s3;
		up_s4   <= up_s3;
		temp_s4 <= temp_s3;
		sq_s4   <= b6_s3 * b6_s3;
		t2_s4   <= ac2 * b6_s3;
		t3_s4   <= ac3 * b6_s3;

		dz_s5   <= dz_s4;
		up_s5   <= up_s4;
		temp_s5 <= temp_s4;
		u1_s5   <= b2 * sq_s4;
		u4_s5   <= b1 * sq_s4;
		t2_s5   <= t2_s4;
		t3_s5   <= t3_s4;

		dz_s6   <= dz_s5;
		up_s6   <= up_s5;
		temp_s6 <= temp_s5;
		b3_s6   <= asr(b3v + (b3v[31] ? 32'd3 : 32'd0), 5'd2);
		y3_s6   <= y3c;

		dz_s7   <= dz_s6;
		temp_s7 <= temp_s6;
		b4p_s7  <= ac4 * (y3_s6 + B4_OFS);
		b7_s7   <= ({13'd0, up_s6} - b3_s6) * (P_SCALE >> oss_q);

		num_s8  <= b7_s7[31] ? b7_s7 : (b7_s7 << 1);
		den_s8  <= (b4 == 32'd0) ? 32'd1 : b4;
		side_s8 <= {temp_s7, b7_s7[31], dz_s7 || (b4 == 32'd0)};
	end

	logic           v_d2;
	logic [31:0]    q_d2;
	logic [SW2-1:0] side_d2;

	bpcu_div #(.SW(SW2)) u_div_p (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s8),
		.in_num    (num_s8),
		.in_den    (den_s8),
		.in_side   (side_s8),
		.out_valid (v_d2),
		.out_quot  (q_d2),
		.out_side  (side_d2)
	);

	// stage 9: p and p >> 8
	logic        v_s9, err_s9;
	logic [31:0] temp_s9, p_s9, xa_s9;
	logic [31:0] pq;

	assign pq = side_d2[1] ? (q_d2 << 1) : q_d2;

	// stage 10: square and linear term
	logic        v_s10, err_s10;
	logic [31:0] temp_s10, p_s10, sqa_s10, x2_s10;

	// stage 11: scale the square
	logic        v_s11, err_s11;
	logic [31:0] temp_s11, p_s11, m_s11, x2_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			done  <= 1'b0;
		end else begin
			v_s9  <= v_d2;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			done  <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		err_s9   <= side_d2[0];
		temp_s9  <= side_d2[33:2];
		p_s9     <= pq;
		xa_s9    <= asr(pq, 5'd8);

		err_s10  <= err_s9;
		temp_s10 <= temp_s9;
		p_s10    <= p_s9;
		sqa_s10  <= xa_s9 * xa_s9;
		x2_s10   <= asr(K_LIN * p_s9, 5'd16);

		err_s11  <= err_s10;
		temp_s11 <= temp_s10;
		p_s11    <= p_s10;
		m_s11    <= sqa_s10 * K_SQ;
		x2_s11   <= x2_s10;

		temp_tenths <= temp_s11;
		div_error   <= err_s11;
		pressure_pa <= err_s11 ? 32'd0 :
			p_s11 + asr(asr(m_s11, 5'd16) + x2_s11 + K_OFS, 5'd4);
	end

endmodule

### rtl/bpcu_chk.sv
// port-level checker for the pressure compensation unit, bound to the top level
`include "barometric_pressure_compensation_unit_defines.svh"

module bpcu_chk
	import bpcu_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] temp_tenths,
	input logic [31:0] pressure_pa,
	input logic        div_error
);

	`BPCU_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
	`BPCU_ASSERT(a_result_follows, (start && !busy) |-> ##LATENCY done, "result missing")
	`BPCU_ASSERT(a_no_spurious, done |-> $past(start, LATENCY), "result without transfer")
	`BPCU_ASSERT(a_err_zero, (done && div_error) |-> (pressure_pa == 32'd0), "pressure not zero")

endmodule

bind barometric_pressure_compensation_unit bpcu_chk u_bpcu_chk (.*);
